// ----- hw/rtl/csdp_pkg.sv -----
// shared types and constants for the clock source divider picker
`default_nettype none
package csdp_pkg;
   localparam int RATE_REGS = 4;
   localparam int RATE_W    = 32;
   localparam int DIV_W     = 16;
   localparam int IDX_W     = 2;
   localparam int CNT_W     = 3;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SOURCES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_0      = 3'd1;

   typedef enum logic [1:0] {
      ST_FIT       = 2'd0,
      ST_OVERSHOOT = 2'd1,
      ST_NO_SOURCE = 2'd2,
      ST_ZERO_REQ  = 2'd3
   } status_type;

   typedef struct packed {
      logic [RATE_W-1:0] requested_hz;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  source_index;
      logic [DIV_W-1:0]  divider;
      logic [RATE_W-1:0] achieved_hz;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [RATE_W-1:0]    data;
   } csr_type;
endpackage
`default_nettype wire

// ----- hw/rtl/csdp_if.sv -----
// valid/ready channel interface
`default_nettype none
interface csdp_if #(parameter int W = 32);
   logic         valid;
   logic         ready;
   logic [W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/clock_source_divider_picker.sv -----
// top level: csr bank, per-source division lanes, selection and output register
`default_nettype none
// One request word in, one response word out. A request enters every cycle
// unless the pipeline is held; a response word is valid once its request has
// passed 33 register stages of ceiling divide and 32 of rate over divider in
// each source lane, then the output register, the first stage loading at
// the accepting edge. All sources run in parallel lanes; a final stage picks
// the fastest fitting source, or the slowest usable one with the maximum
// divider. The pipeline holds while the output register is full and not
// taken. Rate registers must only be written while no request is in flight.
module clock_source_divider_picker
   import csdp_pkg::*;
#(
   parameter int MAX_DIVIDER = 65534,
   parameter int NUM_SOURCES = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   csdp_if.sink      req,
   csdp_if.source    rsp,
   csdp_if.sink      csr
);
   localparam int NS = (NUM_SOURCES < RATE_REGS) ? NUM_SOURCES : RATE_REGS;
   localparam int LAT = 2 * RATE_W + 1;
   localparam int SIDE_W = RATE_W + CNT_W;

   logic [CNT_W-1:0]  num_ff;
   logic [RATE_W-1:0] rate_ff [RATE_REGS];
   csr_type           csr_w;
   assign csr_w     = csr.payload;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff     <= CNT_W'(4);
         rate_ff[0] <= 32'd200000000;
         rate_ff[1] <= 32'd100000000;
         rate_ff[2] <= 32'd50000000;
         rate_ff[3] <= 32'd24000000;
      end else if (csr.valid) begin
         if (csr_w.index == CSR_NUM_SOURCES) num_ff <= CNT_W'(csr_w.data);
         else if (csr_w.index <= CSR_IDX_W'(RATE_REGS))
            rate_ff[IDX_W'(csr_w.index - CSR_RATE_0)] <= csr_w.data;
      end
   end

   // output register with stall
   logic    out_vld_ff;
   rsp_type out_ff, out_in;
   logic    en;
   assign en        = !out_vld_ff || rsp.ready;
   assign req.ready = en;
   req_type rq;
   assign rq = req.payload;

   logic [CNT_W-1:0] n_eff;
   assign n_eff = (num_ff > CNT_W'(NS)) ? CNT_W'(NS) : num_ff;

   logic [NS-1:0]     lv, lfit;
   logic [DIV_W-1:0]  ldiv [NS];
   logic [RATE_W-1:0] lact [NS];
   logic [RATE_W-1:0] lrate [NS];

   for (genvar i = 0; i < NS; i++) begin : g_lane
      logic [RATE_W-1:0] r_use;
      assign r_use = (CNT_W'(i) < n_eff) ? rate_ff[i] : '0;
      csdp_src #(.MAX_DIVIDER(MAX_DIVIDER)) u_src (
         .clock, .reset, .en,
         .in_valid (req.valid),
         .in_req   (rq.requested_hz),
         .in_rate  (r_use),
         .out_valid(lv[i]),
         .out_fits (lfit[i]),
         .out_div  (ldiv[i]),
         .out_act  (lact[i])
      );
      // the user keeps rates static while busy (not enforced here), so sample gated rate at the output
      assign lrate[i] = r_use;
   end

   // request delay line to align zero-request flag
   logic [LAT-1:0] zero_ff;
   always_ff @(posedge clock) begin
      if (en) zero_ff <= {zero_ff[LAT-2:0], rq.requested_hz == '0};
   end

   always_comb begin
      logic              found, any;
      logic [IDX_W-1:0]  bi, si;
      logic [DIV_W-1:0]  bd;
      logic [RATE_W-1:0] ba, sr;
      found = 1'b0; any = 1'b0; bi = '0; si = '0; bd = '0; ba = '0; sr = '0;
      for (int i = 0; i < NS; i++) begin
         if (lrate[i] != '0) begin
            if (!any || lrate[i] < sr) begin
               si = IDX_W'(i);
               sr = lrate[i];
            end
            any = 1'b1;
            if (lfit[i] && (!found || lact[i] > ba)) begin
               found = 1'b1; ba = lact[i]; bd = ldiv[i]; bi = IDX_W'(i);
            end
         end
      end
      out_in = '0;
      if (zero_ff[LAT-1]) out_in.status = ST_ZERO_REQ;
      else if (!any) out_in.status = ST_NO_SOURCE;
      else if (found) begin
         out_in.source_index = bi; out_in.divider = bd;
         out_in.achieved_hz = ba; out_in.status = ST_FIT;
      end else begin
         out_in.source_index = si; out_in.divider = DIV_W'(MAX_DIVIDER);
         out_in.achieved_hz = lact[si]; out_in.status = ST_OVERSHOOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (en) out_vld_ff <= lv[0];
      if (en) out_ff <= out_in;
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.payload = out_ff;

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("response changed under stall");
   a_div_even: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> out_ff.divider[0] == 1'b0)
      else $error("odd divider");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && out_ff.status != ST_FIT && out_ff.status != ST_OVERSHOOT
      |-> out_ff.divider == '0)
      else $error("divider set without a source");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/csdp_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with sideband
`default_nettype none
module csdp_div
   import csdp_pkg::*;
#(
   parameter int NW = 33,
   parameter int DW = 32,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] in_num,
   input  wire logic [DW-1:0] in_den,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   output logic [NW-1:0]      out_quo,
   output logic [SW-1:0]      out_side
);
   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic          vld_prev;
      logic [NW-1:0] rem_prev;
      logic [NW-1:0] quo_prev;
      logic [NW-1:0] num_prev;
      logic [DW-1:0] den_prev;
      logic [SW-1:0] side_prev;
      logic [NW:0]   trial;
      logic          ge;
      logic          vld_ff;
      logic [NW-1:0] rem_ff;
      logic [NW-1:0] quo_ff;
      logic [NW-1:0] num_ff;
      logic [DW-1:0] den_ff;
      logic [SW-1:0] side_ff;

      if (s == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign quo_prev  = '0;
         assign num_prev  = in_num;
         assign den_prev  = in_den;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = g_stage[s-1].vld_ff;
         assign rem_prev  = g_stage[s-1].rem_ff;
         assign quo_prev  = g_stage[s-1].quo_ff;
         assign num_prev  = g_stage[s-1].num_ff;
         assign den_prev  = g_stage[s-1].den_ff;
         assign side_prev = g_stage[s-1].side_ff;
      end

      assign trial = {rem_prev, num_prev[NW-1-s]};
      assign ge    = trial >= {{(NW+1-DW){1'b0}}, den_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_prev;
         end
         if (en) begin
            rem_ff  <= ge ? NW'(trial - {{(NW+1-DW){1'b0}}, den_prev})
                          : NW'(trial);
            quo_ff  <= {quo_prev[NW-2:0], ge};
            num_ff  <= num_prev;
            den_ff  <= den_prev;
            side_ff <= side_prev;
         end
      end
   end

   assign out_valid = g_stage[NW-1].vld_ff;
   assign out_quo   = g_stage[NW-1].quo_ff;
   assign out_side  = g_stage[NW-1].side_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/csdp_src.sv -----
// per-source lane: ceiling divide, divider rounding, achieved rate divide
`default_nettype none
module csdp_src
   import csdp_pkg::*;
#(
   parameter int MAX_DIVIDER = 65534
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [RATE_W-1:0] in_req,
   input  wire logic [RATE_W-1:0] in_rate,
   output logic                   out_valid,
   output logic                   out_fits,
   output logic [DIV_W-1:0]       out_div,
   output logic [RATE_W-1:0]      out_act
);
   localparam int NW = RATE_W + 1;
   logic              v1;
   logic [NW-1:0]     q1;
   logic [RATE_W-1:0] rate1;
   logic [NW-1:0]     k_raw;
   logic [NW-1:0]     k_even;
   logic              fits;
   logic [DIV_W-1:0]  kdiv;
   logic [RATE_W-1:0] q2;
   logic [DIV_W:0]    side2;

   // ceil(rate/req) = (rate + req - 1) / req, 33-bit numerator
   csdp_div #(.NW(NW), .DW(RATE_W), .SW(RATE_W)) u_ceil (
      .clock, .reset, .en,
      .in_valid (in_valid),
      .in_num   (NW'(in_rate) + NW'(in_req) - NW'(1)),
      .in_den   (in_req),
      .in_side  (in_rate),
      .out_valid(v1),
      .out_quo  (q1),
      .out_side (rate1)
   );

   always_comb begin
      if (q1 < NW'(2)) k_raw = NW'(2);
      else k_raw = q1 + NW'(q1[0]);
      k_even = k_raw;
      fits   = (k_even <= NW'(MAX_DIVIDER)) && (rate1 != '0);
      kdiv   = fits ? DIV_W'(k_even) : DIV_W'(MAX_DIVIDER);
   end

   csdp_div #(.NW(RATE_W), .DW(RATE_W), .SW(DIV_W+1)) u_act (
      .clock, .reset, .en,
      .in_valid (v1),
      .in_num   (rate1),
      .in_den   (RATE_W'(kdiv)),
      .in_side  ({fits, kdiv}),
      .out_valid(out_valid),
      .out_quo  (q2),
      .out_side (side2)
   );

   assign out_act  = q2;
   assign out_fits = side2[DIV_W];
   assign out_div  = side2[DIV_W-1:0];
endmodule
`default_nettype wire
